FILE: rtl/pa2tl_pkg.sv
// Package for primitive assembly to triangle list.
// Holds the field widths, the opcode and mode codes, the sequencer state type and
// the structs that pass between modules. It depends on nothing.
package pa2tl_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int BUCKET_LIMIT = 256;
    localparam int SLOT_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = SLOT_W + 1;
    localparam int HANDLE_W     = 32;
    localparam int MODE_W       = 4;
    localparam int OPC_W        = 2;
    localparam int BUCKET_W     = 4;
    localparam int BUCKET_STEPS = $clog2(MAX_VERTICES / BUCKET_LIMIT);
    localparam int DRAW_LIMIT   = 8;

    localparam logic [OPC_W-1:0] OPC_BEGIN  = 2'd0;
    localparam logic [OPC_W-1:0] OPC_VERTEX = 2'd1;
    localparam logic [OPC_W-1:0] OPC_END    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_LOOP   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_FAN    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_QUADS  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_QSTRIP = 4'd8;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_ISSUE  = 1'b1;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_COPY0,
        OP_COPY1,
        OP_HANDLE,
        OP_LOOP,
        OP_ISSUE
    } t_op;

    typedef struct packed {
        logic                we;
        logic [SLOT_W-1:0]   waddr;
        logic [HANDLE_W-1:0] wdata;
        logic [SLOT_W-1:0]   raddr;
    } t_ram_req;

    typedef struct packed {
        logic                kind;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] handle;
        logic [CNT_W-1:0]    count;
        logic [BUCKET_W-1:0] bucket;
        logic                drawn;
        logic                last;
    } t_result;

    // number of ceiling halvings that bring count to at most BUCKET_LIMIT
    function automatic logic [BUCKET_W-1:0] bucket_of(input logic [CNT_W-1:0] count);
        logic [BUCKET_W-1:0] b;
        b = '0;
        for (int k = 0; k < BUCKET_STEPS; k++) begin
            if (int'(count) > (BUCKET_LIMIT << k)) begin
                b = BUCKET_W'(k + 1);
            end
        end
        return b;
    endfunction

endpackage

FILE: rtl/primitive_assembly_to_triangle_list_top.sv
// Primitive assembly to triangle list, top level: sequencer, vertex store and
// output beat register. Depends on pa2tl_pkg, pa2tl_seq and pa2tl_ram.
//
// Begin, vertex and end beats enter a one-beat input register; the sequencer takes
// an item from it when idle and then gives one result at a time, since every
// appended slot uses the store's single write port and each issue is a result of its
// own. Begin, ignored beats and end with an empty batch give no result; a plain
// vertex appends its handle; a fan, quad or quad-strip vertex that copies two earlier
// slots appends both copies, then its handle; an end issues the batch, a line-loop
// end after re-appending slot 0. A held output register stalls the sequence. Copy
// reads are issued ahead of their writes, for the op that runs next. The input
// register takes a beat while it is empty or its item is being taken, also while an
// item is at work or a result waits. The store holds no valid state and needs no clearing after reset.
module primitive_assembly_to_triangle_list_top
    import pa2tl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OPC_W-1:0]    i_opcode,
    input  logic [MODE_W-1:0]   i_prim_mode,
    input  logic [HANDLE_W-1:0] i_vertex_handle,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_result_kind,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [HANDLE_W-1:0] o_out_handle,
    output logic [CNT_W-1:0]    o_batch_count,
    output logic [BUCKET_W-1:0] o_bucket,
    output logic                o_drawn,
    output logic                o_last
);

    t_ram_req            ram_req;
    logic [HANDLE_W-1:0] rd_data;
    t_result             res;
    logic                res_valid;
    logic                res_rdy;
    logic                r_out_valid;
    t_result             r_out;

    assign res_rdy = !r_out_valid || !i_out_stall;

    pa2tl_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_prim_mode    (i_prim_mode),
        .i_vertex_handle(i_vertex_handle),
        .i_res_rdy      (res_rdy),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .o_ram          (ram_req),
        .i_rd_data      (rd_data)
    );

    pa2tl_ram u_ram (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (ram_req),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (res_rdy && res_valid) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_rdy) begin
            r_out_valid <= res_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out.kind;
    assign o_slot        = r_out.slot;
    assign o_out_handle  = r_out.handle;
    assign o_batch_count = r_out.count;
    assign o_bucket      = r_out.bucket;
    assign o_drawn       = r_out.drawn;
    assign o_last        = r_out.last;

endmodule

FILE: rtl/pa2tl_ram.sv
// Vertex handle store: one write port, one registered read port.
// A read of the slot written at the same edge returns the new data.
// Depends on pa2tl_pkg.
module pa2tl_ram
    import pa2tl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ram_req            i_req,
    output logic [HANDLE_W-1:0] o_rd_data
);

    logic [HANDLE_W-1:0] r_mem [MAX_VERTICES];
    logic [HANDLE_W-1:0] r_rd;
    logic [HANDLE_W-1:0] r_byp_data;
    logic                r_byp;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd       <= r_mem[i_req.raddr];
        r_byp_data <= i_req.wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= i_req.we && (i_req.waddr == i_req.raddr);
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd;

endmodule

FILE: rtl/pa2tl_seq.sv
// Command sequencer: input beat register, batch state and the per-item op sequence
// that reads and appends slots of the vertex store and issues batches.
// Depends on pa2tl_pkg; drives the store in pa2tl_ram.
module pa2tl_seq
    import pa2tl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OPC_W-1:0]    i_opcode,
    input  logic [MODE_W-1:0]   i_prim_mode,
    input  logic [HANDLE_W-1:0] i_vertex_handle,
    input  logic                i_res_rdy,
    output logic                o_res_valid,
    output t_result             o_res,
    output t_ram_req            o_ram,
    input  logic [HANDLE_W-1:0] i_rd_data
);

    logic                r_in_valid;
    logic [OPC_W-1:0]    r_in_opcode;
    logic [MODE_W-1:0]   r_in_mode;
    logic [HANDLE_W-1:0] r_in_handle;

    t_op                 r_op,       n_op;
    logic [SLOT_W-1:0]   r_src0,     n_src0;
    logic [SLOT_W-1:0]   r_src1,     n_src1;
    logic [HANDLE_W-1:0] r_handle,   n_handle;
    logic                r_in_batch, n_in_batch;
    logic [MODE_W-1:0]   r_mode,     n_mode;
    logic [CNT_W-1:0]    r_count,    n_count;
    logic [2:0]          r_mod6,     n_mod6;

    logic                take;
    logic                go;
    logic                full_next;
    logic [SLOT_W-1:0]   c_slot;
    logic [CNT_W-1:0]    count_inc;
    logic [2:0]          mod6_inc;

    assign take       = r_in_valid && (r_op == OP_IDLE);
    assign o_in_stall = r_in_valid && !take;
    assign go         = i_res_rdy;
    assign c_slot     = r_count[SLOT_W-1:0];
    assign count_inc  = r_count + CNT_W'(1);
    assign mod6_inc   = (r_mod6 == 3'd5) ? 3'd0 : r_mod6 + 3'd1;
    assign full_next  = (count_inc == CNT_W'(MAX_VERTICES));

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_opcode <= i_opcode;
            r_in_mode   <= i_prim_mode;
            r_in_handle <= i_vertex_handle;
        end
        r_src0   <= n_src0;
        r_src1   <= n_src1;
        r_handle <= n_handle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_op       <= OP_IDLE;
            r_in_batch <= 1'b0;
            r_mode     <= '0;
            r_count    <= '0;
            r_mod6     <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end
            r_op       <= n_op;
            r_in_batch <= n_in_batch;
            r_mode     <= n_mode;
            r_count    <= n_count;
            r_mod6     <= n_mod6;
        end
    end

    always_comb begin
        n_op        = r_op;
        n_src0      = r_src0;
        n_src1      = r_src1;
        n_handle    = r_handle;
        n_in_batch  = r_in_batch;
        n_mode      = r_mode;
        n_count     = r_count;
        n_mod6      = r_mod6;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_ram.we    = 1'b0;
        o_ram.waddr = c_slot;
        o_ram.wdata = i_rd_data;

        unique case (r_op)
            OP_IDLE: begin
                if (take) begin
                    unique case (r_in_opcode)
                        OPC_BEGIN: begin
                            if (!r_in_batch && (r_in_mode <= MODE_QSTRIP)) begin
                                n_mode     = r_in_mode;
                                n_count    = '0;
                                n_mod6     = '0;
                                n_in_batch = 1'b1;
                            end
                        end
                        OPC_VERTEX: begin
                            if (r_in_batch) begin
                                n_handle = r_in_handle;
                                n_op     = OP_HANDLE;
                                if (r_mode == MODE_FAN && r_count >= CNT_W'(3)) begin
                                    n_op   = OP_COPY0;
                                    n_src0 = '0;
                                    n_src1 = c_slot - SLOT_W'(1);
                                end else if (r_mode == MODE_QUADS && r_mod6 == 3'd3) begin
                                    n_op   = OP_COPY0;
                                    n_src0 = c_slot - SLOT_W'(3);
                                    n_src1 = c_slot - SLOT_W'(1);
                                end else if (r_mode == MODE_QSTRIP) begin
                                    if (r_count == CNT_W'(3)) begin
                                        n_op   = OP_COPY0;
                                        n_src0 = '0;
                                        n_src1 = SLOT_W'(2);
                                    end else if (r_count >= CNT_W'(6)) begin
                                        n_op = OP_COPY0;
                                        if (!r_count[0]) begin
                                            n_src0 = c_slot - SLOT_W'(1);
                                            n_src1 = c_slot - SLOT_W'(2);
                                        end else begin
                                            n_src0 = c_slot - SLOT_W'(3);
                                            n_src1 = c_slot - SLOT_W'(1);
                                        end
                                    end
                                end
                            end
                        end
                        OPC_END: begin
                            if (r_in_batch) begin
                                n_in_batch = 1'b0;
                                if (r_count != '0) begin
                                    if (r_mode == MODE_LOOP &&
                                        r_count < CNT_W'(MAX_VERTICES)) begin
                                        n_op = OP_LOOP;
                                    end else begin
                                        n_op = OP_ISSUE;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            OP_COPY0, OP_COPY1, OP_HANDLE, OP_LOOP: begin
                if (go) begin
                    o_res_valid  = 1'b1;
                    o_res.kind   = KIND_APPEND;
                    o_res.slot   = c_slot;
                    o_res.handle = (r_op == OP_HANDLE) ? r_handle : i_rd_data;
                    o_res.last   = (r_op == OP_HANDLE) && !full_next;
                    o_ram.we     = 1'b1;
                    o_ram.wdata  = o_res.handle;
                    n_count      = count_inc;
                    n_mod6       = mod6_inc;
                    if (full_next || r_op == OP_LOOP) begin
                        n_op = OP_ISSUE;
                    end else if (r_op == OP_COPY0) begin
                        n_op = OP_COPY1;
                    end else if (r_op == OP_COPY1) begin
                        n_op = OP_HANDLE;
                    end else begin
                        n_op = OP_IDLE;
                    end
                end
            end
            OP_ISSUE: begin
                if (go) begin
                    o_res_valid  = 1'b1;
                    o_res.kind   = KIND_ISSUE;
                    o_res.count  = r_count;
                    o_res.bucket = bucket_of(r_count);
                    o_res.drawn  = (o_res.bucket < BUCKET_W'(DRAW_LIMIT));
                    o_res.last   = 1'b1;
                    n_count      = '0;
                    n_mod6       = '0;
                    n_op         = OP_IDLE;
                end
            end
            default: begin
                n_op = OP_IDLE;
            end
        endcase

        // read address for the op that runs next; held while stalled
        if (n_op == OP_LOOP) begin
            o_ram.raddr = '0;
        end else if (n_op == OP_COPY1) begin
            o_ram.raddr = n_src1;
        end else begin
            o_ram.raddr = n_src0;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond store size");

    a_issue_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_op == OP_ISSUE) |-> (r_count != '0))
        else $error("issue of empty batch");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.we |-> (r_count < CNT_W'(MAX_VERTICES)))
        else $error("store write into full batch");

    a_issue_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && r_op == OP_ISSUE) |=> (r_count == '0 && r_op == OP_IDLE))
        else $error("count not cleared after issue");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_op != OP_IDLE) |-> !take)
        else $error("item taken while op sequence runs");
`endif

endmodule
